// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define RTFFE_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define RTFFE_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/rtffe_pkg.sv =====
// Package with the codes, field tables and stream widths of the radar field extractor.
`timescale 1ns / 1ps

package rtffe_pkg;

   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 56;

   localparam logic [1:0] KIND_HEADER = 2'd0;
   localparam logic [1:0] KIND_BASIC  = 2'd1;
   localparam logic [1:0] KIND_TARGET = 2'd2;
   localparam logic [1:0] KIND_LANE   = 2'd3;

   localparam logic [15:0] TAG_HEADER = 16'hABCD;
   localparam logic [15:0] TAG_BASIC  = 16'h4A42;
   localparam logic [15:0] TAG_TARGET = 16'h4D42;
   localparam logic [15:0] TAG_LANE   = 16'h444C;

   localparam logic [15:0] TARGET_OVERHEAD = 16'd5;
   localparam logic [15:0] LANE_OVERHEAD   = 16'd2;
   // Division by the 29-byte target record is a multiply by ceil(2^19 / 29), exact for 16 bits.
   localparam logic [15:0] TARGET_RECIP       = 16'd18079;
   localparam int          TARGET_RECIP_SHIFT = 19;
   localparam int          LANE_RECORD_SHIFT  = 2;

   localparam logic [4:0] BASIC_LAST        = 5'd20;
   localparam logic [4:0] TARGET_REC_FIELDS = 5'd16;
   localparam logic [4:0] LANE_REC_FIELDS   = 5'd3;

   localparam logic [2:0] BASIC_WIDTHS [0:20] = '{
      3'd2, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
      3'd1, 3'd1, 3'd1, 3'd1, 3'd2, 3'd1, 3'd1, 3'd2, 3'd1, 3'd2
   };
   localparam logic [2:0] TARGET_WIDTHS [0:16] = '{
      3'd2, 3'd1, 3'd2, 3'd2, 3'd2, 3'd1, 3'd1, 3'd2, 3'd2,
      3'd2, 3'd2, 3'd1, 3'd4, 3'd4, 3'd1, 3'd1, 3'd1
   };
   localparam logic [2:0] LANE_WIDTHS [0:3] = '{3'd2, 3'd1, 3'd2, 3'd1};

   function automatic logic [4:0] rec_fields(input logic [1:0] kind);
      return (kind == KIND_TARGET) ? TARGET_REC_FIELDS : LANE_REC_FIELDS;
   endfunction

   // Byte count of the field at a position; positions past a table take one byte.
   function automatic logic [2:0] field_width(input logic [1:0] kind,
                                              input logic [4:0] pos);
      logic [2:0] width;
      width = 3'd1;
      if (pos == 5'd0 || kind == KIND_HEADER) begin
         width = 3'd2;
      end else begin
         case (kind)
            KIND_BASIC: begin
               if (pos <= BASIC_LAST) width = BASIC_WIDTHS[pos];
            end
            KIND_TARGET: begin
               if (pos <= TARGET_REC_FIELDS) width = TARGET_WIDTHS[pos];
            end
            KIND_LANE: begin
               if (pos <= LANE_REC_FIELDS) width = LANE_WIDTHS[pos[1:0]];
            end
            default: width = 3'd2;
         endcase
      end
      return width;
   endfunction

   function automatic logic is_last(input logic [1:0] kind, input logic [4:0] pos);
      logic last;
      case (kind)
         KIND_HEADER: last = 1'b1;
         KIND_BASIC:  last = (pos >= BASIC_LAST);
         default:     last = (pos > rec_fields(kind));
      endcase
      return last;
   endfunction

endpackage

// ===== rtl/radar_traffic_frame_field_extractor_top.sv =====
// Top level of the radar traffic frame field extractor.
`timescale 1ns / 1ps

// The block takes one byte of the radar frame stream per transaction and returns one
// transaction for every field that completes: the module kind, the field position,
// the 1-based record number inside a target or lane module, the big-endian field value
// and a last flag on the final field of the module. A two-byte tag opens each module;
// an unknown tag is dropped along with both of its bytes. One byte is taken per clock
// while the output register is free or being read: a byte passes through an input
// register, one step of the field table logic, and an output register that holds a field until it is taken.
// The only deep path is the record count of a target module, a 16 by 16 multiply by the
// reciprocal of the record size, done in the same step as the length field.
module radar_traffic_frame_field_extractor_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // Fields from bit 0: in_byte[7:0].
   input  logic [rtffe_pkg::REQ_TDATA_W-1:0]  req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // Fields from bit 0: module_kind[1:0], field_index[6:2], record_index[20:7],
   // field_value[52:21], zero fill[55:53].
   output logic [rtffe_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // Carries module_done.
   output logic                               rsp_tlast
);
   import rtffe_pkg::*;

   typedef enum logic [1:0] {
      PH_TAG1,
      PH_TAG2,
      PH_BODY
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [7:0]  tag_high_ff, tag_high_in;
   logic [1:0]  module_ff, module_in;
   logic [4:0]  pos_ff, pos_in;
   logic [1:0]  bif_ff, bif_in;
   logic [31:0] acc_ff, acc_in;
   logic [13:0] left_ff, left_in;
   logic [13:0] recnum_ff, recnum_in;

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff, in_byte_in;

   logic        out_valid_ff, out_valid_in;
   logic [1:0]  out_kind_ff, out_kind_in;
   logic [4:0]  out_index_ff, out_index_in;
   logic [13:0] out_rec_ff, out_rec_in;
   logic [31:0] out_value_ff, out_value_in;
   logic        out_done_ff, out_done_in;

   logic        go;
   logic [15:0] tag;
   logic [31:0] acc_next;
   logic [2:0]  cnt;
   logic [2:0]  width;
   logic        last;
   logic        in_record;
   logic [4:0]  nrec;
   logic [15:0] len;
   logic [15:0] len_tgt;
   logic [15:0] len_lane;
   logic [31:0] prod;
   logic [13:0] count;
   logic [13:0] left_dec;

   assign go         = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || go;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_done_ff;
   assign rsp_tdata  = {3'b000, out_value_ff, out_rec_ff, out_index_ff, out_kind_ff};

   assign tag       = {tag_high_ff, in_byte_ff};
   assign acc_next  = {acc_ff[23:0], in_byte_ff};
   assign cnt       = {1'b0, bif_ff} + 3'd1;
   assign width     = field_width(module_ff, pos_ff);
   assign last      = is_last(module_ff, pos_ff);
   assign nrec      = rec_fields(module_ff);
   assign in_record = (module_ff == KIND_TARGET || module_ff == KIND_LANE) &&
                      pos_ff >= 5'd1 && pos_ff <= nrec;
   assign len       = acc_next[15:0];
   assign len_tgt   = len - TARGET_OVERHEAD;
   assign len_lane  = len - LANE_OVERHEAD;
   assign prod      = {16'b0, len_tgt} * {16'b0, TARGET_RECIP};
   assign left_dec  = left_ff - 14'd1;

   always_comb begin
      count = 14'd0;
      if (module_ff == KIND_TARGET) begin
         if (len >= TARGET_OVERHEAD) count = 14'(prod >> TARGET_RECIP_SHIFT);
      end else begin
         if (len >= LANE_OVERHEAD) count = 14'(len_lane >> LANE_RECORD_SHIFT);
      end
   end

   always_comb begin
      phase_in    = phase_ff;
      tag_high_in = tag_high_ff;
      module_in   = module_ff;
      pos_in      = pos_ff;
      bif_in      = bif_ff;
      acc_in      = acc_ff;
      left_in     = left_ff;
      recnum_in   = recnum_ff;

      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_tdata;
      end else if (go) begin
         in_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff && !rsp_tready;
      out_kind_in  = out_kind_ff;
      out_index_in = out_index_ff;
      out_rec_in   = out_rec_ff;
      out_value_in = out_value_ff;
      out_done_in  = out_done_ff;

      if (go) begin
         case (phase_ff)
            PH_TAG1: begin
               tag_high_in = in_byte_ff;
               phase_in    = PH_TAG2;
            end
            PH_TAG2: begin
               phase_in = PH_BODY;
               case (tag)
                  TAG_HEADER: module_in = KIND_HEADER;
                  TAG_BASIC:  module_in = KIND_BASIC;
                  TAG_TARGET: module_in = KIND_TARGET;
                  TAG_LANE:   module_in = KIND_LANE;
                  default:    phase_in  = PH_TAG1;
               endcase
               pos_in = 5'd0;
               bif_in = 2'd0;
               acc_in = 32'd0;
            end
            PH_BODY: begin
               if (cnt < width) begin
                  bif_in = cnt[1:0];
                  acc_in = acc_next;
               end else begin
                  out_valid_in = 1'b1;
                  out_kind_in  = module_ff;
                  out_index_in = pos_ff;
                  out_rec_in   = in_record ? recnum_ff : 14'd0;
                  out_value_in = acc_next;
                  out_done_in  = last;
                  bif_in       = 2'd0;
                  acc_in       = 32'd0;
                  if (last) begin
                     phase_in = PH_TAG1;
                     pos_in   = 5'd0;
                  end else if (module_ff == KIND_BASIC) begin
                     pos_in = pos_ff + 5'd1;
                  end else if (pos_ff == 5'd0) begin
                     left_in = count;
                     if (count != 14'd0) begin
                        recnum_in = 14'd1;
                        pos_in    = 5'd1;
                     end else begin
                        recnum_in = 14'd0;
                        pos_in    = nrec + 5'd1;
                     end
                  end else if (pos_ff == nrec) begin
                     left_in = left_dec;
                     if (left_dec != 14'd0) begin
                        recnum_in = recnum_ff + 14'd1;
                        pos_in    = 5'd1;
                     end else begin
                        pos_in = nrec + 5'd1;
                     end
                  end else begin
                     pos_in = pos_ff + 5'd1;
                  end
               end
            end
            default: phase_in = PH_TAG1;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_TAG1;
         tag_high_ff  <= 8'd0;
         module_ff    <= KIND_HEADER;
         pos_ff       <= 5'd0;
         bif_ff       <= 2'd0;
         acc_ff       <= 32'd0;
         left_ff      <= 14'd0;
         recnum_ff    <= 14'd0;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         tag_high_ff  <= tag_high_in;
         module_ff    <= module_in;
         pos_ff       <= pos_in;
         bif_ff       <= bif_in;
         acc_ff       <= acc_in;
         left_ff      <= left_in;
         recnum_ff    <= recnum_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_byte_ff   <= in_byte_in;
      out_kind_ff  <= out_kind_in;
      out_index_ff <= out_index_in;
      out_rec_ff   <= out_rec_in;
      out_value_ff <= out_value_in;
      out_done_ff  <= out_done_in;
   end

endmodule

// ===== rtl/rtffe_checker.sv =====
// Port checker for the radar field extractor and its bind to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rtffe_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic [rtffe_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [rtffe_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input logic                               rsp_tlast
);
   import rtffe_pkg::*;

   `RTFFE_ASSERT_NXT(a_rsp_hold, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "Result changed while stalled.")
   `RTFFE_ASSERT_IMP(a_quiet_after_reset, $past(reset), !rsp_tvalid,
      "Result shown right after reset.")
   `RTFFE_ASSERT_IMP(a_header_last, rsp_tvalid && rsp_tdata[1:0] == KIND_HEADER, rsp_tlast,
      "Header module did not end on its length field.")
   `RTFFE_ASSERT_IMP(a_length_no_record, rsp_tvalid && rsp_tdata[6:2] == 5'd0,
      rsp_tdata[20:7] == 14'd0 && rsp_tdata[55:53] == 3'b000,
      "Length field carried a record number.")
   `RTFFE_ASSERT_IMP(a_lane_range, rsp_tvalid && rsp_tdata[1:0] == KIND_LANE,
      rsp_tdata[6:2] <= 5'd4, "Lane field position out of range.")

endmodule

bind radar_traffic_frame_field_extractor_top rtffe_checker u_rtffe_checker (.*);

// ===== bench/testbench.sv =====
// Self-checking testbench that streams radar frame bytes into the extractor and checks each field.
`timescale 1ns / 1ps

module testbench;
   import rtffe_pkg::*;

   localparam int TARGET_RECORD_BYTES = 29;
   localparam int LANE_RECORD_BYTES   = 4;
   localparam int HOLD_CYCLES         = 400;
   localparam int TAIL_CYCLES         = 20;
   localparam int MAX_REPORTS         = 10;
   localparam int TARGET_FIELD_BYTES [0:16] = '{
      2, 1, 2, 2, 2, 1, 1, 2, 2, 2, 2, 1, 4, 4, 1, 1, 1
   };

   typedef enum logic [1:0] {WAIT_TAG_HI, WAIT_TAG_LO, IN_BODY} parse_phase_type;

   typedef struct {
      logic [1:0]  kind;
      logic [4:0]  index;
      logic [13:0] record;
      logic [31:0] value;
      logic        done;
   } field_result_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tlast;
   logic                   hold_trigger = 1'b0;
   int                     hold_left = 0;

   logic [7:0]       stream_bytes[$];
   field_result_type expected_fields[$];
   int               pushed_count = 0;
   int               accepted_count = 0;
   int               error_count = 0;
   int               send_idle_pct = 0;
   int               recv_idle_pct = 0;

   parse_phase_type parse_phase = WAIT_TAG_HI;
   logic [7:0]      tag_hi = '0;
   logic [1:0]      cur_kind = '0;
   logic [4:0]      cur_pos = '0;
   int              got_bytes = 0;
   logic [31:0]     acc = '0;
   logic [13:0]     recs_left = '0;
   logic [13:0]     rec_num = '0;

   radar_traffic_frame_field_extractor_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int field_bytes(input logic [1:0] kind, input logic [4:0] pos);
      if (pos == 5'd0 || kind == KIND_HEADER) return 2;
      if (kind == KIND_BASIC) return (pos == 5'd15 || pos == 5'd18 || pos == 5'd20) ? 2 : 1;
      if (kind == KIND_TARGET && pos <= TARGET_REC_FIELDS) return TARGET_FIELD_BYTES[pos];
      if (kind == KIND_LANE && pos == 5'd2) return 2;
      return 1;
   endfunction

   function automatic void predict_fields(input logic [7:0] b);
      field_result_type f;
      logic             repeating;
      logic [4:0]       last_rec;
      logic [15:0]      len;
      int unsigned      count;
      case (parse_phase)
         WAIT_TAG_HI: begin
            tag_hi = b;
            parse_phase = WAIT_TAG_LO;
         end
         WAIT_TAG_LO: begin
            parse_phase = IN_BODY;
            case ({tag_hi, b})
               TAG_HEADER: cur_kind = KIND_HEADER;
               TAG_BASIC:  cur_kind = KIND_BASIC;
               TAG_TARGET: cur_kind = KIND_TARGET;
               TAG_LANE:   cur_kind = KIND_LANE;
               default:    parse_phase = WAIT_TAG_HI;
            endcase
            cur_pos = '0;
            got_bytes = 0;
            acc = '0;
         end
         default: begin
            acc = {acc[23:0], b};
            got_bytes++;
            if (got_bytes >= field_bytes(cur_kind, cur_pos)) begin
               repeating = (cur_kind == KIND_TARGET || cur_kind == KIND_LANE);
               last_rec = (cur_kind == KIND_TARGET) ? TARGET_REC_FIELDS : LANE_REC_FIELDS;
               f.kind = cur_kind;
               f.index = cur_pos;
               f.value = acc;
               f.done = (cur_kind == KIND_HEADER) ||
                        (cur_kind == KIND_BASIC && cur_pos >= BASIC_LAST) ||
                        (repeating && cur_pos > last_rec);
               f.record = (repeating && cur_pos != 5'd0 && cur_pos <= last_rec) ? rec_num : '0;
               expected_fields.push_back(f);
               if (f.done) begin
                  parse_phase = WAIT_TAG_HI;
                  cur_pos = '0;
               end else if (!repeating) begin
                  cur_pos++;
               end else if (cur_pos == 5'd0) begin
                  len = acc[15:0];
                  if (cur_kind == KIND_TARGET)
                     count = (len >= TARGET_OVERHEAD) ?
                             (len - TARGET_OVERHEAD) / TARGET_RECORD_BYTES : 0;
                  else
                     count = (len >= LANE_OVERHEAD) ? (len - LANE_OVERHEAD) / LANE_RECORD_BYTES : 0;
                  recs_left = count[13:0];
                  if (recs_left != '0) begin
                     rec_num = 14'd1;
                     cur_pos = 5'd1;
                  end else begin
                     rec_num = '0;
                     cur_pos = last_rec + 5'd1;
                  end
               end else if (cur_pos == last_rec) begin
                  recs_left--;
                  if (recs_left != '0) begin
                     rec_num++;
                     cur_pos = 5'd1;
                  end else begin
                     cur_pos = last_rec + 5'd1;
                  end
               end else begin
                  cur_pos++;
               end
               got_bytes = 0;
               acc = '0;
            end
         end
      endcase
   endfunction

   function automatic void report_error(input string msg);
      error_count++;
      if (error_count <= MAX_REPORTS) $display("%s", msg);
   endfunction

   function automatic void check_field(input logic [RSP_TDATA_W-1:0] data, input logic last);
      field_result_type got;
      field_result_type want;
      got.kind = data[1:0];
      got.index = data[6:2];
      got.record = data[20:7];
      got.value = data[52:21];
      got.done = last;
      if (expected_fields.size() == 0) begin
         report_error($sformatf("unexpected field: kind %0d index %0d record %0d value %h done %b",
                                got.kind, got.index, got.record, got.value, got.done));
         return;
      end
      want = expected_fields.pop_front();
      if (got.kind !== want.kind || got.index !== want.index || got.record !== want.record ||
          got.value !== want.value || got.done !== want.done)
         report_error($sformatf({"field mismatch: expected kind %0d index %0d record %0d ",
                                 "value %h done %b, got kind %0d index %0d record %0d ",
                                 "value %h done %b"},
                                want.kind, want.index, want.record, want.value, want.done,
                                got.kind, got.index, got.record, got.value, got.done));
   endfunction

   function automatic void push_byte(input logic [7:0] b);
      stream_bytes.push_back(b);
      pushed_count++;
   endfunction

   function automatic void push_word(input logic [15:0] w);
      push_byte(w[15:8]);
      push_byte(w[7:0]);
   endfunction

   // Pushes a well-formed module with random contents and returns its size in bytes.
   function automatic int push_module(input logic [1:0] kind, input logic [15:0] len);
      int body;
      body = 1;
      case (kind)
         KIND_HEADER: push_word(TAG_HEADER);
         KIND_BASIC:  push_word(TAG_BASIC);
         KIND_TARGET: push_word(TAG_TARGET);
         default:     push_word(TAG_LANE);
      endcase
      push_word(len);
      case (kind)
         KIND_HEADER: body = 0;
         KIND_BASIC: begin
            body = 0;
            for (int p = 1; p <= BASIC_LAST; p++) body += field_bytes(kind, p[4:0]);
         end
         KIND_TARGET: begin
            if (len >= TARGET_OVERHEAD)
               body += (len - TARGET_OVERHEAD) / TARGET_RECORD_BYTES * TARGET_RECORD_BYTES;
         end
         default: begin
            if (len >= LANE_OVERHEAD)
               body += (len - LANE_OVERHEAD) / LANE_RECORD_BYTES * LANE_RECORD_BYTES;
         end
      endcase
      repeat (body) push_byte(8'($urandom_range(255)));
      return body + 4;
   endfunction

   // Mostly well-formed modules; the rest are unknown or corrupted tags that keep pair alignment.
   task automatic push_traffic(input int budget);
      int          carried;
      int          pick;
      logic [15:0] tag;
      logic [15:0] len;
      logic [1:0]  kind;
      carried = 0;
      while (carried < budget) begin
         pick = $urandom_range(99);
         if (pick < 15) begin
            if (pick < 8) begin
               tag = 16'($urandom_range(16'hFFFF));
            end else begin
               case ($urandom_range(3))
                  0:       tag = TAG_HEADER;
                  1:       tag = TAG_BASIC;
                  2:       tag = TAG_TARGET;
                  default: tag = TAG_LANE;
               endcase
               tag = tag ^ (16'h1 << $urandom_range(15));
            end
            if (tag != TAG_HEADER && tag != TAG_BASIC && tag != TAG_TARGET && tag != TAG_LANE)
               push_word(tag);
         end else begin
            kind = 2'($urandom_range(3));
            case (kind)
               KIND_TARGET: len = ($urandom_range(9) == 0) ? 16'($urandom_range(4)) :
                                                             16'($urandom_range(5, 149));
               KIND_LANE:   len = ($urandom_range(9) == 0) ? 16'($urandom_range(1)) :
                                                             16'($urandom_range(2, 53));
               default:     len = 16'($urandom_range(16'hFFFF));
            endcase
            carried += push_module(kind, len);
         end
      end
   endtask

   task automatic wait_drained();
      while (accepted_count != pushed_count || expected_fields.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_fields(req_tdata);
            accepted_count++;
         end
         if (!req_tvalid || req_tready) begin
            if (stream_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_tvalid <= 1'b1;
               req_tdata <= stream_bytes.pop_front();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_field(rsp_tdata, rsp_tlast);
         rsp_tready <= !hold_trigger && hold_left == 0 && $urandom_range(99) >= recv_idle_pct;
      end
   end

   always @(posedge clock) begin
      if (hold_trigger) begin
         hold_left <= HOLD_CYCLES;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   initial begin
      #10_000_000;
      $display("testbench: done, errors");
      $finish;
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 38;
      recv_idle_pct = 75;
      push_word(16'hFFFF);
      push_word(TAG_HEADER);
      push_word(16'hFFFF);
      push_word(16'h0000);
      push_word(TAG_TARGET);
      push_word(16'h0004);
      push_byte(8'h00);
      push_word(TAG_LANE);
      push_word(16'h0001);
      push_byte(8'hFF);
      push_word(TAG_LANE);
      push_word(16'h0006);
      push_byte(8'hFF);
      push_word(16'h8001);
      push_byte(8'h00);
      push_byte(8'h7F);
      wait_drained();

      push_traffic(500);
      wait_drained();

      send_idle_pct = 75;
      recv_idle_pct = 38;
      push_traffic(500);
      wait_drained();

      // The receiver holds off while the sender keeps offering, so the block must stall its input.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      push_traffic(500);
      @(posedge clock);
      hold_trigger <= 1'b1;
      @(posedge clock);
      hold_trigger <= 1'b0;
      void'(push_module(KIND_LANE, 16'd42));
      void'(push_module(KIND_TARGET, 16'd92));
      wait_drained();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule
